[hdl/vae_pkg.sv]
package vae_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_FRAME      = 2'd0,
        MODE_SPEAK_START = 2'd1,
        MODE_SPEAK_DONE = 2'd2,
        MODE_INTERRUPT  = 2'd3
    } t_mode;

    // Agent phase codes as seen on the result port
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LISTEN = 2'd1;
    localparam logic [1:0] PH_THINK  = 2'd2;
    localparam logic [1:0] PH_SPEAK  = 2'd3;

    // Register map
    localparam int          CFG_IDX_W       = 3;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [2:0]  CFG_SCORE_THR   = 3'd0;
    localparam logic [2:0]  CFG_ENERGY_THR  = 3'd1;
    localparam logic [2:0]  CFG_MIN_RUN     = 3'd2;
    localparam logic [2:0]  CFG_HANGOVER    = 3'd3;
    localparam logic [2:0]  CFG_MAX_UTT     = 3'd4;
    localparam logic [2:0]  CFG_BARGE_EN    = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_SCORE_THR  = 16'd32768;
    localparam logic [15:0] RST_ENERGY_THR = 16'd655;
    localparam logic [7:0]  RST_MIN_RUN    = 8'd3;
    localparam logic [9:0]  RST_HANGOVER   = 10'd30;
    localparam logic [15:0] RST_MAX_UTT    = 16'd1500;
    localparam logic        RST_BARGE_EN   = 1'b1;

endpackage

[hdl/voice_activity_endpointer.sv]
// Voice activity endpointer. Each transaction on the input channel is an audio
// frame (speech when both score and energy reach their thresholds) or an
// external event (speak start, speak done, interrupt); each produces exactly
// one result transaction with the agent phase after the item, start/end/barge-in
// pulses and the current utterance length. Throughput is one item per clock
// while results are taken: an input register feeds a single stage of compare
// and counter logic whose result is held in an output register. While a result
// waits, the input register takes one more item and then the input stalls until
// the result is taken. Configuration writes are accepted every cycle and must
// only be issued while no item is in flight.
module voice_activity_endpointer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_vad_score,
    input  logic [15:0] i_frame_energy,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_agent_state,
    output logic        o_speech_start,
    output logic        o_speech_end,
    output logic        o_barge_in,
    output logic [15:0] o_utterance_length,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [vae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vae_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE   = vae_pkg::PH_IDLE,
        ST_LISTEN = vae_pkg::PH_LISTEN,
        ST_THINK  = vae_pkg::PH_THINK,
        ST_SPEAK  = vae_pkg::PH_SPEAK
    } t_phase;

    // configuration registers
    logic [15:0] r_score_thr;
    logic [15:0] r_energy_thr;
    logic [7:0]  r_min_run;
    logic [9:0]  r_hangover;
    logic [15:0] r_max_utt;
    logic        r_barge_en;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_mode;
    logic [15:0] r_score;
    logic [15:0] r_energy;

    // endpointer state
    t_phase      r_phase,  n_phase;
    logic [7:0]  r_speech_run, n_speech_run;
    logic [9:0]  r_silence_run, n_silence_run;
    logic [15:0] r_utt_cnt, n_utt_cnt;

    // result register
    logic        r_out_valid;
    logic        r_start, n_start;
    logic        r_end,   n_end;
    logic        r_barge, n_barge;

    logic        w_advance;
    logic        w_speech;
    logic [7:0]  w_run_inc;
    logic [9:0]  w_sil_next;
    logic [15:0] w_utt_inc;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr  <= vae_pkg::RST_SCORE_THR;
            r_energy_thr <= vae_pkg::RST_ENERGY_THR;
            r_min_run    <= vae_pkg::RST_MIN_RUN;
            r_hangover   <= vae_pkg::RST_HANGOVER;
            r_max_utt    <= vae_pkg::RST_MAX_UTT;
            r_barge_en   <= vae_pkg::RST_BARGE_EN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                vae_pkg::CFG_SCORE_THR:  r_score_thr  <= i_cfg_data;
                vae_pkg::CFG_ENERGY_THR: r_energy_thr <= i_cfg_data;
                vae_pkg::CFG_MIN_RUN:    r_min_run    <= i_cfg_data[7:0];
                vae_pkg::CFG_HANGOVER:   r_hangover   <= i_cfg_data[9:0];
                vae_pkg::CFG_MAX_UTT:    r_max_utt    <= i_cfg_data;
                vae_pkg::CFG_BARGE_EN:   r_barge_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_mode   <= i_mode;
            r_score  <= i_vad_score;
            r_energy <= i_frame_energy;
        end
    end

    // frame classification and saturating increments
    assign w_speech  = (r_score >= r_score_thr) && (r_energy >= r_energy_thr);
    assign w_run_inc = (r_speech_run == 8'hFF) ? r_speech_run : r_speech_run + 8'd1;
    assign w_utt_inc = (r_utt_cnt == 16'hFFFF) ? r_utt_cnt : r_utt_cnt + 16'd1;
    assign w_sil_next = w_speech ? 10'd0 :
                        ((r_silence_run == 10'h3FF) ? r_silence_run
                                                     : r_silence_run + 10'd1);

    // next state for the item in the input register
    always_comb begin
        n_phase       = r_phase;
        n_speech_run  = r_speech_run;
        n_silence_run = r_silence_run;
        n_utt_cnt     = r_utt_cnt;
        n_start       = 1'b0;
        n_end         = 1'b0;
        n_barge       = 1'b0;
        unique case (vae_pkg::t_mode'(r_mode))
            vae_pkg::MODE_FRAME: begin
                unique case (r_phase)
                    ST_IDLE: begin
                        if (w_speech) begin
                            n_speech_run = w_run_inc;
                            if (w_run_inc >= r_min_run) begin
                                n_phase       = ST_LISTEN;
                                n_speech_run  = 8'd0;
                                n_silence_run = 10'd0;
                                n_utt_cnt     = 16'd0;
                                n_start       = 1'b1;
                            end
                        end else begin
                            n_speech_run = 8'd0;
                        end
                    end
                    ST_LISTEN: begin
                        n_utt_cnt     = w_utt_inc;
                        n_silence_run = w_sil_next;
                        if (w_sil_next >= r_hangover || w_utt_inc >= r_max_utt) begin
                            n_phase       = ST_THINK;
                            n_silence_run = 10'd0;
                            n_speech_run  = 8'd0;
                            n_end         = 1'b1;
                        end
                    end
                    default: begin
                        // thinking or speaking: only a barge-in run matters
                        if (r_barge_en && w_speech) begin
                            n_speech_run = w_run_inc;
                            if (w_run_inc >= r_min_run) begin
                                n_phase       = ST_LISTEN;
                                n_speech_run  = 8'd0;
                                n_silence_run = 10'd0;
                                n_utt_cnt     = 16'd0;
                                n_start       = 1'b1;
                                n_barge       = 1'b1;
                            end
                        end else begin
                            n_speech_run = 8'd0;
                        end
                    end
                endcase
            end
            vae_pkg::MODE_SPEAK_START: n_phase = ST_SPEAK;
            vae_pkg::MODE_SPEAK_DONE: begin
                if (r_phase == ST_SPEAK) begin
                    n_phase = ST_IDLE;
                end
            end
            vae_pkg::MODE_INTERRUPT: begin
                n_phase       = ST_IDLE;
                n_speech_run  = 8'd0;
                n_silence_run = 10'd0;
                n_utt_cnt     = 16'd0;
            end
            default: ;
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ST_IDLE;
            r_speech_run  <= 8'd0;
            r_silence_run <= 10'd0;
            r_utt_cnt     <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_phase       <= n_phase;
                r_speech_run  <= n_speech_run;
                r_silence_run <= n_silence_run;
                r_utt_cnt     <= n_utt_cnt;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
        if (w_advance) begin
            r_start <= n_start;
            r_end   <= n_end;
            r_barge <= n_barge;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_agent_state      = r_phase;
    assign o_speech_start     = r_start;
    assign o_speech_end       = r_end;
    assign o_barge_in         = r_barge;
    assign o_utterance_length = r_utt_cnt;

    // a start always lands in listening with a cleared length
    a_start_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speech_start) |->
            (o_agent_state == vae_pkg::PH_LISTEN && o_utterance_length == 16'd0))
        else $error("speech_start without entering listening");

    // an end always lands in thinking
    a_end_think: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speech_end) |-> (o_agent_state == vae_pkg::PH_THINK))
        else $error("speech_end without entering thinking");

    // barge-in is a kind of start
    a_barge_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_barge_in) |-> (o_speech_start && !o_speech_end))
        else $error("barge_in without speech_start");

    // a stalled result must not be overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_agent_state) && $stable(o_utterance_length)))
        else $error("result changed while stalled");

endmodule
